>>> rtl/i2cpb_pkg.sv
// Shared types, codes and stream field positions for the I2C bus to packet bridge.
package i2cpb_pkg;

    localparam int QUEUE_DEPTH_DEF = 128;

    localparam int SDATA_W = 16;
    localparam int SUSER_W = 2;
    localparam int MDATA_W = 16;
    localparam int MUSER_W = 3;

    // bit positions in m_tdata
    localparam int MD_SEND_VALID  = 0;
    localparam int MD_SEND_VALUE  = 1;
    localparam int MD_DRIVE_VALID = 9;
    localparam int MD_DRIVE_LEVEL = 10;
    localparam int MD_HALT        = 11;
    localparam int MD_RESUME      = 12;

    typedef enum logic [1:0] {
        KIND_SDA  = 2'd0,
        KIND_SCL  = 2'd1,
        KIND_ACK  = 2'd2,
        KIND_DATA = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        PKT_START   = 3'd0,
        PKT_STOP    = 3'd1,
        PKT_ADDRESS = 3'd2,
        PKT_WRITE   = 3'd3,
        PKT_READREQ = 3'd4,
        PKT_MACK    = 3'd5
    } pkt_t;

    typedef enum logic [4:0] {
        PH_IDLE     = 5'b00001,
        PH_ADDRESS  = 5'b00010,
        PH_READ     = 5'b00100,
        PH_WRITE    = 5'b01000,
        PH_RESPONSE = 5'b10000
    } phase_t;

    typedef struct packed {
        logic       send_valid;
        pkt_t       send_type;
        logic [7:0] send_value;
        logic       drive_valid;
        logic       drive_level;
        logic       halt_request;
        logic       resume;
        logic       last;
    } result_t;

endpackage

>>> rtl/i2c_bus_to_packet_bridge_core.sv
// Top level of the I2C bus to packet bridge: event decode, bit queue and result buffer.
//
//  channel | direction | tdata / tuser / tlast
//  s_      | in        | tdata: sda_level, scl_level, packet_value; tuser: kind
//  m_      | out       | tdata: send_valid, send_value, drive_valid, drive_level,
//          |           |        halt_request, resume; tuser: send_type; tlast: last
//
// An accepted item is decoded while it sits in the input register, and its first result
// is registered as the item leaves it; a new item is taken every cycle while the buffer has
// room. The item after a two-result item waits in the input register, as the result port
// delivers one per cycle while m_tready is high. Reset is synchronous; the queue RAM needs
// no clearing pass. m_tready low backs up through the result buffer into the input register.
module i2c_bus_to_packet_bridge_core #(
    parameter int QUEUE_DEPTH = i2cpb_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [0] sda_level, [1] scl_level, [9:2] packet_value, rest zero
    input  logic [i2cpb_pkg::SDATA_W-1:0] s_tdata,
    // [1:0] kind
    input  logic [i2cpb_pkg::SUSER_W-1:0] s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [0] send_valid, [8:1] send_value, [9] drive_valid, [10] drive_level,
    // [11] halt_request, [12] resume, rest zero
    output logic [i2cpb_pkg::MDATA_W-1:0] m_tdata,
    // [2:0] send_type
    output logic [i2cpb_pkg::MUSER_W-1:0] m_tuser,
    output logic                          m_tlast
);
    import i2cpb_pkg::*;

    localparam int PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int LEN_W     = 4;
    localparam int BYTE_BITS = 8;
    localparam int ENTRY_W   = LEN_W + BYTE_BITS;

    // input register
    logic        in_valid_reg;
    kind_t       in_kind_reg;
    logic        in_sda_reg;
    logic        in_scl_reg;
    logic [7:0]  in_value_reg;

    // bus state
    phase_t      phase_reg, phase_next;
    logic [7:0]  bit_cnt_reg, bit_cnt_next;
    logic [7:0]  shift_reg, shift_next;
    logic        read_xfer_reg, read_xfer_next;
    logic        tgt_acked_reg, tgt_acked_next;
    logic        mst_acks_reg, mst_acks_next;
    logic        prev_sda_reg, prev_sda_next;
    logic        prev_scl_reg, prev_scl_next;

    // bit queue: front entry in flops, the rest as entries in RAM
    logic [LEN_W-1:0] front_len_reg, front_len_next;
    logic [7:0]       front_data_reg, front_data_next;
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] ent_cnt_reg, ent_cnt_next;
    logic [CNT_W-1:0] fill_reg, fill_next;

    logic               ram_wr_en;
    logic [PTR_W-1:0]   ram_rd_addr;
    logic [ENTRY_W-1:0] ram_wr_data;
    logic [ENTRY_W-1:0] ram_rd_data;

    // result buffer
    logic [1:0]  res_cnt_reg;
    result_t     res0_reg, res1_reg;
    result_t     res_a, res_b;

    // event decode
    pkt_t        send0_type, send1_type;
    logic [7:0]  send0_value, send1_value;
    logic [1:0]  nsend;
    logic [1:0]  n_res;
    logic        drive_en;
    logic        pop_req;
    logic        halt_ev;
    logic        resume_ev;
    logic        flush;
    logic [LEN_W-1:0] push_len;
    logic [7:0]       push_data;
    logic [CNT_W-1:0] free_bits;
    logic             pop_level;

    logic        out_free;
    logic        proc_fire;

    // ------------------------------------------------------------------
    // Event decode
    // ------------------------------------------------------------------
    always_comb begin
        logic [7:0] cnt_inc;
        logic [7:0] shift_in;
        logic       tgt_drives;
        logic       mack;

        phase_next     = phase_reg;
        bit_cnt_next   = bit_cnt_reg;
        shift_next     = shift_reg;
        read_xfer_next = read_xfer_reg;
        tgt_acked_next = tgt_acked_reg;
        mst_acks_next  = mst_acks_reg;
        prev_scl_next  = prev_scl_reg;
        send0_type     = PKT_START;
        send1_type     = PKT_START;
        send0_value    = 8'd0;
        send1_value    = 8'd0;
        nsend          = 2'd0;
        drive_en       = 1'b0;
        pop_req        = 1'b0;
        halt_ev        = 1'b0;
        resume_ev      = 1'b0;
        flush          = 1'b0;
        push_len       = '0;
        push_data      = 8'd0;
        cnt_inc        = bit_cnt_reg + 8'd1;
        shift_in       = {shift_reg[6:0], in_sda_reg};
        tgt_drives     = 1'b0;
        mack           = 1'b0;
        free_bits      = CNT_W'(QUEUE_DEPTH) - fill_reg;

        unique case (in_kind_reg)
            KIND_SDA: begin
                if (in_scl_reg) begin
                    if (prev_sda_reg && !in_sda_reg) begin
                        flush        = 1'b1;
                        send0_type   = PKT_START;
                        nsend        = 2'd1;
                        phase_next   = PH_ADDRESS;
                        bit_cnt_next = 8'd0;
                        shift_next   = 8'd0;
                    end else if (!prev_sda_reg && in_sda_reg) begin
                        send0_type = PKT_STOP;
                        nsend      = 2'd1;
                        phase_next = PH_IDLE;
                    end
                end
            end
            KIND_SCL: begin
                prev_scl_next = in_scl_reg;
                if (!prev_scl_reg && in_scl_reg) begin
                    if (phase_reg != PH_IDLE) begin
                        bit_cnt_next = cnt_inc;
                    end
                    if (phase_reg == PH_ADDRESS || phase_reg == PH_WRITE) begin
                        shift_next = shift_in;
                    end
                    if (phase_reg == PH_ADDRESS && cnt_inc == 8'd8) begin
                        read_xfer_next = shift_in[0];
                    end
                end else if (prev_scl_reg && !in_scl_reg) begin
                    tgt_drives = (phase_reg == PH_READ && bit_cnt_reg < 8'd8) ||
                                 (phase_reg == PH_RESPONSE && tgt_acked_reg &&
                                  bit_cnt_reg == 8'd0);
                    if (tgt_drives) begin
                        drive_en = 1'b1;
                        pop_req  = 1'b1;
                    end else if (phase_reg == PH_READ) begin
                        drive_en = 1'b1;
                    end else if (phase_reg == PH_RESPONSE && !read_xfer_reg) begin
                        drive_en = 1'b1;
                    end

                    if ((phase_reg == PH_ADDRESS || phase_reg == PH_WRITE) &&
                        bit_cnt_reg == 8'd8) begin
                        send0_type    = (phase_reg == PH_ADDRESS) ? PKT_ADDRESS : PKT_WRITE;
                        send0_value   = shift_reg;
                        nsend         = 2'd1;
                        phase_next    = PH_RESPONSE;
                        mst_acks_next = 1'b0;
                        bit_cnt_next  = 8'd0;
                        halt_ev       = 1'b1;
                    end else if (phase_reg == PH_READ && bit_cnt_reg == 8'd8) begin
                        phase_next    = PH_RESPONSE;
                        mst_acks_next = 1'b1;
                        bit_cnt_next  = 8'd0;
                    end else if (phase_reg == PH_RESPONSE) begin
                        // a low SDA sampled in the ack slot means the master acked
                        mack = mst_acks_reg && bit_cnt_reg == 8'd1;
                        if (mack) begin
                            send0_type  = PKT_MACK;
                            send0_value = {7'd0, !prev_sda_reg};
                        end
                        phase_next   = read_xfer_reg ? PH_READ : PH_WRITE;
                        bit_cnt_next = 8'd0;
                        shift_next   = 8'd0;
                        if (read_xfer_reg) begin
                            halt_ev = 1'b1;
                            if (mack) begin
                                send1_type = PKT_READREQ;
                                nsend      = 2'd2;
                            end else begin
                                send0_type = PKT_READREQ;
                                nsend      = 2'd1;
                            end
                        end else if (mack) begin
                            nsend = 2'd1;
                        end
                    end
                end
            end
            KIND_ACK: begin
                tgt_acked_next = in_value_reg != 8'd0;
                resume_ev      = 1'b1;
                if (fill_reg != CNT_W'(QUEUE_DEPTH)) begin
                    push_len  = LEN_W'(1);
                    push_data = {in_value_reg == 8'd0, 7'd0};
                    if (phase_reg == PH_RESPONSE && bit_cnt_reg == 8'd0) begin
                        drive_en = 1'b1;
                        pop_req  = 1'b1;
                    end
                end
            end
            KIND_DATA: begin
                resume_ev = 1'b1;
                push_data = in_value_reg;
                // drop the bits that do not fit
                push_len  = (free_bits >= CNT_W'(BYTE_BITS)) ? LEN_W'(BYTE_BITS)
                                                              : LEN_W'(free_bits);
                if (phase_reg == PH_READ && bit_cnt_reg == 8'd0) begin
                    drive_en = 1'b1;
                    pop_req  = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Bit queue: push first, then pop one bit from the front entry
    // ------------------------------------------------------------------
    always_comb begin
        logic [LEN_W-1:0] eff_len;
        logic [7:0]       eff_data;
        logic             to_mem;
        logic             take_mem;
        logic             popped;

        eff_len   = front_len_reg;
        eff_data  = front_data_reg;
        to_mem    = push_len != '0;
        take_mem  = 1'b0;
        popped    = 1'b0;
        pop_level = 1'b1;

        if (front_len_reg == '0) begin
            eff_len  = push_len;
            eff_data = push_data;
            to_mem   = 1'b0;
        end

        front_len_next  = eff_len;
        front_data_next = eff_data;

        if (pop_req && eff_len != '0) begin
            popped          = 1'b1;
            pop_level       = eff_data[7];
            front_len_next  = eff_len - LEN_W'(1);
            front_data_next = {eff_data[6:0], 1'b0};
            if (eff_len == LEN_W'(1)) begin
                // refill the front from the oldest entry, or take the new one
                if (ent_cnt_reg != '0) begin
                    front_len_next  = ram_rd_data[ENTRY_W-1 -: LEN_W];
                    front_data_next = ram_rd_data[BYTE_BITS-1:0];
                    take_mem        = 1'b1;
                end else if (to_mem) begin
                    front_len_next  = push_len;
                    front_data_next = push_data;
                    to_mem          = 1'b0;
                end
            end
        end

        tail_next    = tail_reg;
        head_next    = head_reg;
        if (to_mem) begin
            tail_next = (tail_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + PTR_W'(1);
        end
        if (take_mem) begin
            head_next = (head_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + PTR_W'(1);
        end
        ent_cnt_next = ent_cnt_reg + CNT_W'(to_mem) - CNT_W'(take_mem);
        fill_next    = fill_reg + CNT_W'(push_len) - CNT_W'(popped);
        ram_wr_en    = proc_fire && to_mem;

        if (flush) begin
            front_len_next = '0;
            head_next      = '0;
            tail_next      = '0;
            ent_cnt_next   = '0;
            fill_next      = '0;
        end

        prev_sda_next = prev_sda_reg;
        if (in_kind_reg == KIND_SDA) begin
            prev_sda_next = in_sda_reg;
        end else if (pop_req) begin
            prev_sda_next = pop_level;
        end
    end

    assign ram_wr_data = {push_len, push_data};
    assign ram_rd_addr = proc_fire ? head_next : head_reg;

    i2cpb_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (tail_reg),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // ------------------------------------------------------------------
    // Result assembly and handshake
    // ------------------------------------------------------------------
    always_comb begin
        if (nsend != 2'd0) begin
            n_res = nsend;
        end else begin
            n_res = (drive_en || halt_ev || resume_ev) ? 2'd1 : 2'd0;
        end

        res_a.send_valid   = nsend != 2'd0;
        res_a.send_type    = send0_type;
        res_a.send_value   = send0_value;
        res_a.drive_valid  = drive_en;
        res_a.drive_level  = pop_req ? pop_level : 1'b1;
        res_a.halt_request = (n_res == 2'd1) && halt_ev;
        res_a.resume       = (n_res == 2'd1) && resume_ev;
        res_a.last         = n_res == 2'd1;

        res_b.send_valid   = 1'b1;
        res_b.send_type    = send1_type;
        res_b.send_value   = send1_value;
        res_b.drive_valid  = 1'b0;
        res_b.drive_level  = 1'b1;
        res_b.halt_request = halt_ev;
        res_b.resume       = resume_ev;
        res_b.last         = 1'b1;
    end

    assign out_free  = (res_cnt_reg == 2'd0) || (res_cnt_reg == 2'd1 && m_tready);
    assign proc_fire = in_valid_reg && (out_free || n_res == 2'd0);
    assign s_tready  = !in_valid_reg || proc_fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (proc_fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_kind_reg  <= kind_t'(s_tuser);
            in_sda_reg   <= s_tdata[0];
            in_scl_reg   <= s_tdata[1];
            in_value_reg <= s_tdata[9:2];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            bit_cnt_reg    <= 8'd0;
            shift_reg      <= 8'd0;
            read_xfer_reg  <= 1'b0;
            tgt_acked_reg  <= 1'b0;
            mst_acks_reg   <= 1'b0;
            prev_sda_reg   <= 1'b1;
            prev_scl_reg   <= 1'b1;
            front_len_reg  <= '0;
            front_data_reg <= 8'd0;
            head_reg       <= '0;
            tail_reg       <= '0;
            ent_cnt_reg    <= '0;
            fill_reg       <= '0;
        end else if (proc_fire) begin
            phase_reg      <= phase_next;
            bit_cnt_reg    <= bit_cnt_next;
            shift_reg      <= shift_next;
            read_xfer_reg  <= read_xfer_next;
            tgt_acked_reg  <= tgt_acked_next;
            mst_acks_reg   <= mst_acks_next;
            prev_sda_reg   <= prev_sda_next;
            prev_scl_reg   <= prev_scl_next;
            front_len_reg  <= front_len_next;
            front_data_reg <= front_data_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            ent_cnt_reg    <= ent_cnt_next;
            fill_reg       <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_cnt_reg <= 2'd0;
        end else if (proc_fire && n_res != 2'd0) begin
            res_cnt_reg <= n_res;
        end else if (m_tvalid && m_tready) begin
            res_cnt_reg <= res_cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc_fire && n_res != 2'd0) begin
            res0_reg <= res_a;
            res1_reg <= res_b;
        end else if (m_tvalid && m_tready && res_cnt_reg == 2'd2) begin
            // advance the second result of the pair
            res0_reg <= res1_reg;
        end
    end

    assign m_tvalid = res_cnt_reg != 2'd0;
    assign m_tdata  = {3'b000, res0_reg.resume, res0_reg.halt_request,
                       res0_reg.drive_level, res0_reg.drive_valid,
                       res0_reg.send_value, res0_reg.send_valid};
    assign m_tuser  = res0_reg.send_type;
    assign m_tlast  = res0_reg.last;

endmodule

>>> rtl/i2cpb_ram.sv
// Generic single-port-write, single-port-read RAM with registered, write-first read data.
module i2cpb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // forward a same-address write so a fresh entry is visible next cycle
    always_ff @(posedge aclk) begin
        if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_reg <= wr_data;
        end else begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/i2cpb_checker.sv
// Port-level checks on the result stream of the I2C bus to packet bridge, bound to the top.
module i2cpb_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [i2cpb_pkg::MDATA_W-1:0] m_tdata,
    input logic [i2cpb_pkg::MUSER_W-1:0] m_tuser,
    input logic                          m_tlast
);
    import i2cpb_pkg::*;

    // hold a stalled item
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
                                  $stable(m_tlast))
        else $error("result item changed while stalled");

    // the first of two results always carries a packet
    a_pair_sends: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tdata[MD_SEND_VALID])
        else $error("non-final result without a packet");

    a_halt_resume: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[MD_HALT] || m_tdata[MD_RESUME]) |->
            m_tlast && !(m_tdata[MD_HALT] && m_tdata[MD_RESUME]))
        else $error("halt or resume off the final result, or both set");

    a_idle_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[MD_SEND_VALID] |->
            m_tuser == PKT_START && m_tdata[MD_SEND_VALUE +: 8] == 8'd0 &&
            (m_tdata[MD_DRIVE_VALID] || m_tdata[MD_DRIVE_LEVEL]))
        else $error("unused result fields not at their idle values");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind i2c_bus_to_packet_bridge_core i2cpb_checker u_i2cpb_checker (.*);
